### rtl/toc_pkg.sv
// ----------------------------------------------------------------------------
// toc_pkg
// Shared types and constants for the tinted over-composite pixel pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package toc_pkg;

  // Channel and arithmetic widths
  localparam int unsigned CH_W     = 8;   // one color or alpha channel
  localparam int unsigned PROD_W   = 16;  // product of two channels
  localparam int unsigned NA_W     = 24;  // coverage numerator, up to 255*65025
  localparam int unsigned NUM_W    = 32;  // color numerator, up to 65025*65025
  localparam int unsigned DIV_STEPS = CH_W; // one quotient bit per stage
  localparam int unsigned NCH      = 3;   // red, green, blue

  // 1.0 * 1.0 in the product scale
  localparam logic [PROD_W-1:0] FULL_SQ    = 16'd65025;
  localparam logic [NA_W-1:0]   ALPHA_DIV  = 24'd65025;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TINT_RED    = 2'd0,
    REG_TINT_GREEN  = 2'd1,
    REG_TINT_BLUE   = 2'd2,
    REG_LAYER_ALPHA = 2'd3
  } toc_reg_t;

  // Register reset values
  localparam logic [CH_W-1:0] TINT_RED_RST    = 8'd255;
  localparam logic [CH_W-1:0] TINT_GREEN_RST  = 8'd38;
  localparam logic [CH_W-1:0] TINT_BLUE_RST   = 8'd38;
  localparam logic [CH_W-1:0] LAYER_ALPHA_RST = 8'd89;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [NA_W-1:0]   na_t;
  typedef logic [NUM_W-1:0]  num_t;

endpackage : toc_pkg

`default_nettype wire

### rtl/tinted_over_composite_top.sv
// ----------------------------------------------------------------------------
// tinted_over_composite_top
// Straight-alpha "over" of a tinted, layer-faded source pixel onto a
// destination pixel, RGBA8, one pixel per clock while out_tready is not held low.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata[63:0]  src RGBA, dst RGBA
//  out_    | master    | out_tvalid/out_tready| out_tdata[31:0] composited RGBA
//  cfg_    | write     | cfg_we               | cfg_index[1:0], cfg_data[7:0]
//
//  One pixel per clock sustained while the output is not stalled; the
//  pipeline is two multiply stages, one add stage, then eight
//  restore-divide stages that each settle one quotient bit.
//  Reset (synchronous, rst_n low) empties the pipeline and loads the
//  register defaults. Each stage holds while its successor is full and
//  stalled, so bubbles close up behind a stalled output and no transfer is
//  lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module tinted_over_composite_top
  import toc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue,
  // dst_alpha (lowest bits first)
  input  wire logic [63:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_red, out_green, out_blue, out_alpha (lowest bits first)
  output logic [31:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int unsigned NSTG = 2 + DIV_STEPS + 1;  // s1, s2, s3, divide steps

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  chan_t tint_red_r, tint_green_r, tint_blue_r, layer_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tint_red_r    <= TINT_RED_RST;
      tint_green_r  <= TINT_GREEN_RST;
      tint_blue_r   <= TINT_BLUE_RST;
      layer_alpha_r <= LAYER_ALPHA_RST;
    end else if (cfg_we) begin
      unique case (toc_reg_t'(cfg_index))
        REG_TINT_RED:    tint_red_r    <= cfg_data;
        REG_TINT_GREEN:  tint_green_r  <= cfg_data;
        REG_TINT_BLUE:   tint_blue_r   <= cfg_data;
        REG_LAYER_ALPHA: layer_alpha_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage valids and ready chain: a stage loads when it is empty or its
  // successor is taking its contents
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int i = NSTG-2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Unpack the input transfer
  // --------------------------------------------------------------------------
  chan_t src_c [NCH];
  chan_t dst_c [NCH];
  chan_t tint_c [NCH];
  chan_t src_alpha, dst_alpha;

  assign src_c[0]  = in_tdata[7:0];
  assign src_c[1]  = in_tdata[15:8];
  assign src_c[2]  = in_tdata[23:16];
  assign src_alpha = in_tdata[31:24];
  assign dst_c[0]  = in_tdata[39:32];
  assign dst_c[1]  = in_tdata[47:40];
  assign dst_c[2]  = in_tdata[55:48];
  assign dst_alpha = in_tdata[63:56];
  assign tint_c[0] = tint_red_r;
  assign tint_c[1] = tint_green_r;
  assign tint_c[2] = tint_blue_r;

  // --------------------------------------------------------------------------
  // Stage 1: channel products
  // --------------------------------------------------------------------------
  prod_t p1_r;                 // src_alpha * layer_alpha
  prod_t sct1_r [NCH];         // src_c * tint_c
  prod_t dcd1_r [NCH];         // dst_c * dst_alpha
  chan_t da1_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p1_r  <= PROD_W'(src_alpha) * PROD_W'(layer_alpha_r);
      da1_r <= dst_alpha;
      for (int c = 0; c < NCH; c++) begin
        sct1_r[c] <= PROD_W'(src_c[c]) * PROD_W'(tint_c[c]);
        dcd1_r[c] <= PROD_W'(dst_c[c]) * PROD_W'(dst_alpha);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: weight by source coverage and its complement
  // --------------------------------------------------------------------------
  prod_t q1;
  na_t   na_nxt;
  num_t  a2_r [NCH];
  num_t  b2_r [NCH];
  na_t   na2_r;

  assign q1     = FULL_SQ - p1_r;
  assign na_nxt = ((NA_W'(p1_r) << 8) - NA_W'(p1_r)) + NA_W'(da1_r) * NA_W'(q1);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      na2_r <= na_nxt;
      for (int c = 0; c < NCH; c++) begin
        a2_r[c] <= NUM_W'(sct1_r[c]) * NUM_W'(p1_r);
        b2_r[c] <= NUM_W'(dcd1_r[c]) * NUM_W'(q1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divide pipeline. Index 0 is stage 3 (sum the numerators); index k+1
  // settles quotient bit DIV_STEPS-1-k by one compare and subtract.
  // --------------------------------------------------------------------------
  num_t  rem_r  [DIV_STEPS+1][NCH];
  chan_t quo_r  [DIV_STEPS+1][NCH];
  na_t   arem_r [DIV_STEPS+1];
  chan_t aquo_r [DIV_STEPS+1];
  na_t   dna_r  [DIV_STEPS+1];
  logic  nz_r   [DIV_STEPS+1];

  // Stage 3: form the numerators, flag zero coverage
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dna_r[0]  <= na2_r;
      nz_r[0]   <= (na2_r != '0);
      arem_r[0] <= na2_r;
      aquo_r[0] <= '0;
      for (int c = 0; c < NCH; c++) begin
        rem_r[0][c] <= a2_r[c] + b2_r[c];
        quo_r[0][c] <= '0;
      end
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int unsigned SH = DIV_STEPS - 1 - k;

    num_t dsh;
    na_t  ash;
    logic age;
    logic ge [NCH];

    assign dsh = NUM_W'(dna_r[k]) << SH;
    assign ash = ALPHA_DIV << SH;
    assign age = (arem_r[k] >= ash);

    always_comb begin
      for (int c = 0; c < NCH; c++) begin
        ge[c] = (rem_r[k][c] >= dsh);
      end
    end

    // Advance one restoring step
    always_ff @(posedge clk) begin
      if (rdy[3+k]) begin
        dna_r[k+1]  <= dna_r[k];
        nz_r[k+1]   <= nz_r[k];
        arem_r[k+1] <= age ? arem_r[k] - ash : arem_r[k];
        aquo_r[k+1] <= {aquo_r[k][CH_W-2:0], age};
        for (int c = 0; c < NCH; c++) begin
          rem_r[k+1][c] <= ge[c] ? rem_r[k][c] - dsh : rem_r[k][c];
          quo_r[k+1][c] <= {quo_r[k][c][CH_W-2:0], ge[c]};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output: last divide stage is the output register; zero coverage gives 0
  // --------------------------------------------------------------------------
  chan_t out_c [NCH];
  chan_t out_a;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      out_c[c] = nz_r[DIV_STEPS] ? quo_r[DIV_STEPS][c] : '0;
    end
    out_a = nz_r[DIV_STEPS] ? aquo_r[DIV_STEPS] : '0;
  end

  assign out_tdata  = {out_a, out_c[2], out_c[1], out_c[0]};
  assign out_tvalid = vld_r[NSTG-1];

endmodule : tinted_over_composite_top

`default_nettype wire

### rtl/toc_checker.sv
// ----------------------------------------------------------------------------
// toc_checker
// Port-level checks for the tinted over-composite pipeline, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module toc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready
);

  // Reset empties the whole pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // An empty or draining output lets the input side take a transfer
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while output side can move");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped during stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output data changed during stall");

endmodule : toc_checker

bind tinted_over_composite_top toc_checker u_toc_checker (.*);

`default_nettype wire
